// File: src/dms_pkg.sv
// shared types, codes and helpers for the degradation mode supervisor
// no dependencies; every other file of the block imports this package
package dms_pkg;

    // operating modes
    localparam logic [1:0] MODE_SAFE = 2'd0;
    localparam logic [1:0] MODE_DEGR = 2'd1;
    localparam logic [1:0] MODE_FULL = 2'd2;
    localparam logic [1:0] MODE_EMER = 2'd3;

    // event codes
    localparam logic [2:0] EV_TICK      = 3'd0;
    localparam logic [2:0] EV_SPEED     = 3'd1;
    localparam logic [2:0] EV_STEER     = 3'd2;
    localparam logic [2:0] EV_LINK_LOSS = 3'd3;
    localparam logic [2:0] EV_PART_FAIL = 3'd4;
    localparam logic [2:0] EV_RECOVER   = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_SPEED = 3'd0;
    localparam logic [2:0] CFG_MAX_STEER = 3'd1;
    localparam logic [2:0] CFG_ALLOW_CACHED = 3'd2;
    localparam logic [2:0] CFG_CACHE_VALIDITY = 3'd3;
    localparam logic [2:0] CFG_MIN_DWELL = 3'd4;

    // configuration reset values
    localparam logic [13:0] RST_MAX_SPEED = 14'd1600;
    localparam logic [14:0] RST_MAX_STEER = 15'd3840;
    localparam logic        RST_ALLOW_CACHED = 1'b1;
    localparam logic [31:0] RST_CACHE_VALIDITY = 32'd2000;
    localparam logic [15:0] RST_MIN_DWELL = 16'd1000;

    // capability mask groups
    localparam logic [5:0] CAP_DRIVE = 6'h03;
    localparam logic [5:0] CAP_HW    = 6'h07;
    localparam logic [5:0] CAP_LINK  = 6'h08;
    localparam logic [5:0] CAP_HOST  = 6'h30;
    localparam logic [5:0] CAP_ODOM  = 6'h20;

    // absolute command limits
    localparam logic signed [15:0] SPEED_LIMIT = 16'sd16000;
    localparam logic signed [15:0] STEER_LIMIT = 16'sd23040;

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        now_ms;
        logic signed [15:0] command_value;
        logic               link_connected;
        logic               link_healthy;
        logic               safe_request;
        logic               estop_active;
        logic               hardware_ready;
        logic [2:0]         fail_cap_bit;
    } item_t;

    typedef struct packed {
        logic               accepted;
        logic               speed_drive;
        logic signed [15:0] speed_out;
        logic               steer_drive;
        logic signed [15:0] steer_out;
        logic [1:0]         mode_now;
        logic [5:0]         capabilities_now;
        logic               system_healthy;
        logic [31:0]        time_in_mode_ms;
    } result_t;

    typedef struct packed {
        logic [13:0] degr_speed_max;
        logic [14:0] max_degraded_steer;
        logic        allow_cached;
        logic [31:0] cache_life_ms;
        logic [15:0] min_dwell_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         op_mode;
        logic [5:0]         cap_mask;
        logic [31:0]        mode_entry_ms;
        logic               persisted_valid;
        logic [31:0]        persisted_ms;
        logic signed [15:0] last_speed;
        logic signed [15:0] last_steer;
        logic signed [15:0] cached_speed;
        logic signed [15:0] cached_steer;
        logic [31:0]        cached_ms;
        logic               cached_valid;
    } state_t;

    typedef struct packed {
        logic               ok;
        logic signed [15:0] lim;
        logic signed [15:0] speed;
        logic signed [15:0] steer;
    } cmd_res_t;

    // clamp a signed value to +-m
    function automatic logic signed [15:0] clamp_sym(input logic signed [15:0] v,
                                                     input logic [14:0] m);
        logic signed [16:0] v17;
        logic signed [16:0] m17;
        logic signed [16:0] n17;
        v17 = {v[15], v};
        m17 = {2'b00, m};
        n17 = -m17;
        if (v17 > m17)
        begin
            return m17[15:0];
        end
        else if (v17 < n17)
        begin
            return n17[15:0];
        end
        return v;
    endfunction

endpackage

// File: src/degradation_mode_supervisor_top.sv
// top level of the degradation mode supervisor: input register, state, result register
// depends on dms_pkg, dms_cfg and dms_step
//
// usage
//   item channel: one event word per handshake (item_valid, item_ready, item)
//   result channel: exactly one result word per event (result_valid, result_ready, result)
//   cfg channel: register writes by index (cfg_valid, cfg_ready, cfg_index, cfg_data);
//     cfg_ready is always high, writes belong in idle periods only
// path: an accepted event passes two register stages: the input register, then the
//   state update and the result register, which are written in the same cycle
// throughput: one event per cycle while result_ready is high, set by the state update loop
// stall: when result_ready is low the result register holds; an empty input register
//   still takes one more word, then item_ready drops until the result is taken
// reset: mode safe, empty capability mask, cache and persisted mark invalid,
//   configuration at its defaults; both channels empty
module degradation_mode_supervisor_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  dms_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output dms_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import dms_pkg::*;

    cfg_t    cfg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    state_t  st_reg;
    state_t  st_next;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;

    dms_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dms_step u_step (
        .item (in_item_reg),
        .cur  (st_reg),
        .cfg  (cfg),
        .nxt  (st_next),
        .res  (res_next)
    );

    assign advance      = in_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
    end

    // supervisor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    a_emer_no_caps: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.op_mode == MODE_EMER |-> st_reg.cap_mask == 6'h00)
        else $error("capabilities present in emergency mode");

    a_mode_change_time: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (st_next.op_mode != st_reg.op_mode) |=> res_reg.time_in_mode_ms == 32'd0)
        else $error("mode change without restarting the mode timer");

    a_drive_needs_hw: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (res_next.speed_drive || res_next.steer_drive)
        |-> in_item_reg.hardware_ready)
        else $error("setpoint issued without hardware ready");

    a_unknown_event_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.mode != EV_TICK) && (in_item_reg.mode != EV_SPEED)
        && (in_item_reg.mode != EV_STEER) && (in_item_reg.mode != EV_LINK_LOSS)
        && (in_item_reg.mode != EV_PART_FAIL) && (in_item_reg.mode != EV_RECOVER)
        |=> st_reg == $past(st_reg))
        else $error("unknown event changed the state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result_ready |-> !advance)
        else $error("pending result word overwritten");

endmodule

// File: src/dms_cfg.sv
// configuration register file of the degradation mode supervisor
// depends on dms_pkg for register indexes, reset values and cfg_t
module dms_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output dms_pkg::cfg_t cfg
);
    import dms_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.degr_speed_max     <= RST_MAX_SPEED;
            cfg_reg.max_degraded_steer <= RST_MAX_STEER;
            cfg_reg.allow_cached       <= RST_ALLOW_CACHED;
            cfg_reg.cache_life_ms      <= RST_CACHE_VALIDITY;
            cfg_reg.min_dwell_ms       <= RST_MIN_DWELL;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_SPEED:      cfg_reg.degr_speed_max <= cfg_data[13:0];
                CFG_MAX_STEER:      cfg_reg.max_degraded_steer <= cfg_data[14:0];
                CFG_ALLOW_CACHED:   cfg_reg.allow_cached <= cfg_data[0];
                CFG_CACHE_VALIDITY: cfg_reg.cache_life_ms <= cfg_data;
                CFG_MIN_DWELL:      cfg_reg.min_dwell_ms <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: src/dms_cmd.sv
// command limiter: mode clamp, acceptance and absolute range check of one command
// depends on dms_pkg for mode codes, limits, clamp_sym and cmd_res_t
module dms_cmd (
    input  dms_pkg::cfg_t     cfg,
    input  logic [1:0]        op_mode,
    input  logic [5:0]        cap_mask,
    input  logic              steer,
    input  logic signed [15:0] value,
    input  logic signed [15:0] last_speed,
    input  logic signed [15:0] last_steer,
    output dms_pkg::cmd_res_t res
);
    import dms_pkg::*;

    logic               can_take;
    logic signed [15:0] lim;
    logic signed [15:0] new_speed;
    logic signed [15:0] new_steer;
    logic               in_range;

    always_comb
    begin
        can_take = (op_mode != MODE_EMER) && ((cap_mask & CAP_DRIVE) == CAP_DRIVE);
        unique case (op_mode)
            MODE_DEGR:
            begin
                lim = steer ? clamp_sym(value, cfg.max_degraded_steer)
                            : clamp_sym(value, {1'b0, cfg.degr_speed_max});
            end
            MODE_FULL: lim = value;
            default:   lim = '0;
        endcase
        new_speed = steer ? last_speed : lim;
        new_steer = steer ? lim : last_steer;
        in_range = (new_speed <= SPEED_LIMIT) && (new_speed >= -SPEED_LIMIT)
                && (new_steer <= STEER_LIMIT) && (new_steer >= -STEER_LIMIT);
        res.ok    = can_take && in_range;
        res.lim   = lim;
        res.speed = new_speed;
        res.steer = new_steer;
    end

endmodule

// File: src/dms_step.sv
// next-state and result logic for one event word of the supervisor
// depends on dms_pkg and dms_cmd
module dms_step (
    input  dms_pkg::item_t   item,
    input  dms_pkg::state_t  cur,
    input  dms_pkg::cfg_t    cfg,
    output dms_pkg::state_t  nxt,
    output dms_pkg::result_t res
);
    import dms_pkg::*;

    logic [5:0]         caps_fresh;
    logic [5:0]         caps_ref;
    logic [31:0]        elapsed;
    logic               cache_fresh;
    logic               persist_fresh;
    logic               estop_enter;
    logic [1:0]         tick_op;
    logic [1:0]         tick_target;
    logic               dwell_ok;
    logic signed [15:0] replay_speed;
    logic signed [15:0] replay_steer;
    logic               cmd_steer;
    logic signed [15:0] cmd_value;
    logic [5:0]         cmd_mask;
    logic [5:0]         pf_mask;
    logic [1:0]         rec_target;
    cmd_res_t           cmd;

    // capability mask rebuilt from the status flags
    assign caps_fresh = (item.link_connected ? CAP_LINK : 6'h00)
                      | ((item.link_connected && item.link_healthy) ? CAP_HOST : 6'h00)
                      | (item.hardware_ready ? CAP_HW : 6'h00);
    assign caps_ref = (cur.op_mode == MODE_EMER) ? 6'h00 : caps_fresh;

    assign elapsed = item.now_ms - cur.mode_entry_ms;
    assign cache_fresh = cur.cached_valid
                      && ((item.now_ms - cur.cached_ms) < cfg.cache_life_ms);
    assign persist_fresh = cur.persisted_valid
                        && ((item.now_ms - cur.persisted_ms) < cfg.cache_life_ms);

    // tick: emergency entry, then automatic mode target
    assign estop_enter = item.estop_active && (cur.op_mode != MODE_EMER);
    assign tick_op = estop_enter ? MODE_EMER : cur.op_mode;
    assign dwell_ok = estop_enter ? (cfg.min_dwell_ms == 16'd0)
                                  : (elapsed >= {16'd0, cfg.min_dwell_ms});

    always_comb
    begin
        tick_target = tick_op;
        if (item.link_healthy && !item.safe_request)
        begin
            tick_target = MODE_FULL;
        end
        else if (item.link_connected)
        begin
            if (tick_op == MODE_SAFE || tick_op == MODE_EMER)
            begin
                tick_target = MODE_DEGR;
            end
        end
        else if (tick_op == MODE_FULL || tick_op == MODE_DEGR)
        begin
            tick_target = MODE_SAFE;
        end
    end

    // cached replay: speed limited from above only
    always_comb
    begin
        if (cur.cached_speed > $signed({2'b00, cfg.degr_speed_max}))
        begin
            replay_speed = $signed({2'b00, cfg.degr_speed_max});
        end
        else
        begin
            replay_speed = cur.cached_speed;
        end
        replay_steer = clamp_sym(cur.cached_steer, cfg.max_degraded_steer);
    end

    // shared command unit
    assign cmd_steer = (item.mode != EV_SPEED);
    assign cmd_value = (item.mode == EV_RECOVER) ? cur.last_steer : item.command_value;
    assign cmd_mask  = (item.mode == EV_RECOVER) ? caps_ref : cur.cap_mask;

    dms_cmd u_cmd (
        .cfg        (cfg),
        .op_mode    (cur.op_mode),
        .cap_mask   (cmd_mask),
        .steer      (cmd_steer),
        .value      (cmd_value),
        .last_speed (cur.last_speed),
        .last_steer (cur.last_steer),
        .res        (cmd)
    );

    // shift past bit 5 falls off the mask, so codes 6 and 7 clear nothing
    assign pf_mask = cur.cap_mask & ~(6'h01 << item.fail_cap_bit);

    assign rec_target = (item.link_healthy && ((caps_ref & CAP_DRIVE) == CAP_DRIVE))
                      ? MODE_FULL : MODE_DEGR;

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.accepted = 1'b1;
        unique case (item.mode)
            EV_TICK:
            begin
                nxt.cap_mask = caps_ref;
                if (item.hardware_ready)
                begin
                    if (cur.op_mode == MODE_DEGR)
                    begin
                        res.speed_drive = 1'b1;
                        res.steer_drive = 1'b1;
                        if (cfg.allow_cached && cache_fresh)
                        begin
                            res.speed_out = replay_speed;
                            res.steer_out = replay_steer;
                        end
                    end
                    else if (cur.op_mode != MODE_FULL)
                    begin
                        res.speed_drive = 1'b1;
                        res.steer_drive = 1'b1;
                    end
                end
                if (estop_enter)
                begin
                    nxt.op_mode         = MODE_EMER;
                    nxt.mode_entry_ms   = item.now_ms;
                    nxt.persisted_valid = 1'b0;
                    nxt.persisted_ms    = '0;
                    nxt.cached_valid    = 1'b0;
                    nxt.cap_mask        = '0;
                    res.speed_out       = '0;
                    res.steer_out       = '0;
                    if (item.hardware_ready)
                    begin
                        res.speed_drive = 1'b1;
                        res.steer_drive = 1'b1;
                    end
                end
                if (tick_target != tick_op && dwell_ok)
                begin
                    nxt.op_mode       = tick_target;
                    nxt.mode_entry_ms = item.now_ms;
                    if (tick_target == MODE_SAFE)
                    begin
                        nxt.cap_mask = caps_ref & ~CAP_ODOM;
                    end
                    else
                    begin
                        nxt.cap_mask = caps_fresh;
                    end
                end
            end
            EV_SPEED, EV_STEER:
            begin
                res.accepted = cmd.ok;
                if (cmd.ok)
                begin
                    nxt.last_speed   = cmd.speed;
                    nxt.last_steer   = cmd.steer;
                    nxt.cached_speed = cmd.speed;
                    nxt.cached_steer = cmd.steer;
                    nxt.cached_ms    = item.now_ms;
                    nxt.cached_valid = 1'b1;
                    if (item.hardware_ready)
                    begin
                        if (cmd_steer)
                        begin
                            res.steer_drive = 1'b1;
                            res.steer_out   = cmd.lim;
                        end
                        else
                        begin
                            res.speed_drive = 1'b1;
                            res.speed_out   = cmd.lim;
                        end
                    end
                end
            end
            EV_LINK_LOSS:
            begin
                nxt.persisted_valid = 1'b1;
                nxt.persisted_ms    = item.now_ms;
                if (cur.op_mode != MODE_SAFE)
                begin
                    nxt.op_mode       = MODE_SAFE;
                    nxt.mode_entry_ms = item.now_ms;
                    nxt.cap_mask      = cur.cap_mask & ~CAP_ODOM;
                end
                if (item.hardware_ready)
                begin
                    nxt.cached_speed = cur.last_speed;
                    nxt.cached_steer = cur.last_steer;
                    nxt.cached_ms    = item.now_ms;
                    nxt.cached_valid = 1'b1;
                end
            end
            EV_PART_FAIL:
            begin
                nxt.cap_mask = pf_mask;
                if (cur.op_mode == MODE_FULL)
                begin
                    nxt.mode_entry_ms = item.now_ms;
                    if ((pf_mask & CAP_DRIVE) != CAP_DRIVE)
                    begin
                        nxt.op_mode  = MODE_SAFE;
                        nxt.cap_mask = pf_mask & ~CAP_ODOM;
                    end
                    else
                    begin
                        nxt.op_mode  = MODE_DEGR;
                        nxt.cap_mask = caps_fresh;
                    end
                end
            end
            EV_RECOVER:
            begin
                nxt.cap_mask = caps_ref;
                if (persist_fresh && item.hardware_ready && cmd.ok)
                begin
                    nxt.last_speed   = cmd.speed;
                    nxt.last_steer   = cmd.steer;
                    nxt.cached_speed = cmd.speed;
                    nxt.cached_steer = cmd.steer;
                    nxt.cached_ms    = item.now_ms;
                    nxt.cached_valid = 1'b1;
                    res.steer_drive  = 1'b1;
                    res.steer_out    = cmd.lim;
                end
                if ((rec_target == MODE_FULL || item.link_connected)
                    && rec_target != cur.op_mode)
                begin
                    nxt.op_mode       = rec_target;
                    nxt.mode_entry_ms = item.now_ms;
                    nxt.cap_mask      = caps_fresh;
                end
            end
            default:
            begin
                res.accepted = 1'b0;
            end
        endcase
        res.mode_now         = nxt.op_mode;
        res.capabilities_now = nxt.cap_mask;
        res.system_healthy   = (nxt.op_mode == MODE_FULL || nxt.op_mode == MODE_DEGR)
                            && item.link_healthy && !item.estop_active;
        res.time_in_mode_ms  = item.now_ms - nxt.mode_entry_ms;
    end

endmodule

// File: tb/degradation_mode_supervisor_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for degradation_mode_supervisor_top: a scoreboard class tracks
// mode, capabilities and command cache and checks every result word field by field
// depends on dms_pkg and the block's RTL
module testbench;
    import dms_pkg::*;

    localparam logic [2:0] EV_UNDEF_A = 3'd6;
    localparam logic [2:0] EV_UNDEF_B = 3'd7;

    // event flag patterns: {link_connected, link_healthy, safe_request, estop_active, hardware_ready}
    localparam logic [4:0] LINK_UP_HW = 5'b11001;
    localparam logic [4:0] LINK_UP_NO_HW = 5'b11000;
    localparam logic [4:0] CONN_ONLY = 5'b10001;
    localparam logic [4:0] ESTOP_HW = 5'b11011;
    localparam logic [4:0] SAFE_REQ_HW = 5'b11101;
    localparam logic [4:0] LINK_DOWN_HW = 5'b00001;

    localparam int CYCLE_LIMIT = 600000;

    class supervisor_board;
        bit [13:0] lim_speed = RST_MAX_SPEED;
        bit [14:0] lim_steer = RST_MAX_STEER;
        bit        replay_ok = RST_ALLOW_CACHED;
        bit [31:0] fresh_ms = RST_CACHE_VALIDITY;
        bit [15:0] dwell_ms = RST_MIN_DWELL;

        bit [1:0]  op = MODE_SAFE;
        bit [5:0]  caps = '0;
        bit [31:0] entry_ms = '0;
        bit        persist_ok = 1'b0;
        bit [31:0] persist_ms = '0;
        int        last_spd = 0;
        int        last_str = 0;
        int        cache_spd = 0;
        int        cache_str = 0;
        bit [31:0] cache_ms = '0;
        bit        cache_ok = 1'b0;

        item_t     ev;
        result_t   res;
        result_t   outcomes[$];
        int        mismatch_count = 0;

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_MAX_SPEED:      lim_speed = data[13:0];
                CFG_MAX_STEER:      lim_steer = data[14:0];
                CFG_ALLOW_CACHED:   replay_ok = data[0];
                CFG_CACHE_VALIDITY: fresh_ms = data;
                CFG_MIN_DWELL:      dwell_ms = data[15:0];
                default: ;
            endcase
        endfunction

        function void refresh_caps();
            caps = '0;
            if (ev.link_connected)
            begin
                caps |= CAP_LINK;
                if (ev.link_healthy)
                begin
                    caps |= CAP_HOST;
                end
            end
            if (ev.hardware_ready)
            begin
                caps |= CAP_HW;
            end
            if (op == MODE_EMER)
            begin
                caps = '0;
            end
        endfunction

        function void enter_mode(bit [1:0] m);
            if (m == op)
            begin
                return;
            end
            op = m;
            entry_ms = ev.now_ms;
            if (m == MODE_FULL || m == MODE_DEGR)
            begin
                refresh_caps();
            end
            else if (m == MODE_SAFE)
            begin
                caps &= ~CAP_ODOM;
            end
            else
            begin
                caps = '0;
            end
        endfunction

        function bit is_fresh(bit valid, bit [31:0] stamp);
            bit [31:0] age;
            age = ev.now_ms - stamp;
            return valid && (age < fresh_ms);
        endfunction

        function bit can_accept();
            return op != MODE_EMER && (caps & CAP_DRIVE) == CAP_DRIVE;
        endfunction

        function void set_drive(int s, int a);
            if (!ev.hardware_ready)
            begin
                return;
            end
            res.speed_drive = 1'b1;
            res.speed_out = s[15:0];
            res.steer_drive = 1'b1;
            res.steer_out = a[15:0];
        endfunction

        function void store_cache(int s, int a);
            cache_spd = s;
            cache_str = a;
            cache_ms = ev.now_ms;
            cache_ok = 1'b1;
        endfunction

        function bit apply_command(bit steer, int v);
            int lim;
            int m;
            int s;
            int a;
            if (!can_accept())
            begin
                return 1'b0;
            end
            lim = v;
            if (op == MODE_DEGR)
            begin
                m = steer ? int'(lim_steer) : int'(lim_speed);
                if (lim > m)
                begin
                    lim = m;
                end
                if (lim < -m)
                begin
                    lim = -m;
                end
            end
            else if (op != MODE_FULL)
            begin
                lim = 0;
            end
            s = steer ? last_spd : lim;
            a = steer ? lim : last_str;
            if ((s < 0 ? -s : s) > int'(SPEED_LIMIT) || (a < 0 ? -a : a) > int'(STEER_LIMIT))
            begin
                return 1'b0;
            end
            last_spd = s;
            last_str = a;
            store_cache(s, a);
            if (ev.hardware_ready)
            begin
                if (steer)
                begin
                    res.steer_drive = 1'b1;
                    res.steer_out = lim[15:0];
                end
                else
                begin
                    res.speed_drive = 1'b1;
                    res.speed_out = lim[15:0];
                end
            end
            return 1'b1;
        endfunction

        function void run_tick();
            int s;
            int a;
            int m;
            bit [1:0] target;
            bit [31:0] age;
            bit ok;
            refresh_caps();
            if (op == MODE_DEGR)
            begin
                if (replay_ok && is_fresh(cache_ok, cache_ms))
                begin
                    s = cache_spd;
                    a = cache_str;
                    m = int'(lim_steer);
                    if (s > int'(lim_speed))
                    begin
                        s = int'(lim_speed);
                    end
                    if (a > m)
                    begin
                        a = m;
                    end
                    if (a < -m)
                    begin
                        a = -m;
                    end
                    set_drive(s, a);
                end
                else
                begin
                    set_drive(0, 0);
                end
            end
            else if (op != MODE_FULL)
            begin
                set_drive(0, 0);
            end
            if (ev.estop_active && op != MODE_EMER)
            begin
                enter_mode(MODE_EMER);
                set_drive(0, 0);
                persist_ok = 1'b0;
                persist_ms = '0;
                cache_ok = 1'b0;
                caps = '0;
            end
            target = op;
            if (ev.link_healthy && !ev.safe_request)
            begin
                target = MODE_FULL;
            end
            else if (ev.link_connected)
            begin
                if (op == MODE_SAFE || op == MODE_EMER)
                begin
                    target = MODE_DEGR;
                end
            end
            else if (op == MODE_FULL || op == MODE_DEGR)
            begin
                target = MODE_SAFE;
            end
            age = ev.now_ms - entry_ms;
            if (target != op && age >= {16'd0, dwell_ms})
            begin
                ok = 1'b1;
                if (target == MODE_FULL)
                begin
                    ok = ev.link_healthy && !ev.safe_request;
                end
                else if (target == MODE_DEGR)
                begin
                    ok = ev.link_connected;
                end
                if (ok)
                begin
                    enter_mode(target);
                end
            end
        endfunction

        function result_t predict_outcome(item_t it);
            bit acc;
            ev = it;
            res = '0;
            acc = 1'b1;
            case (it.mode)
                EV_TICK:  run_tick();
                EV_SPEED: acc = apply_command(1'b0, int'($signed(it.command_value)));
                EV_STEER: acc = apply_command(1'b1, int'($signed(it.command_value)));
                EV_LINK_LOSS:
                begin
                    persist_ok = 1'b1;
                    persist_ms = it.now_ms;
                    enter_mode(MODE_SAFE);
                    if (it.hardware_ready)
                    begin
                        store_cache(last_spd, last_str);
                    end
                end
                EV_PART_FAIL:
                begin
                    if (it.fail_cap_bit < 3'd6)
                    begin
                        caps &= ~(6'b000001 << it.fail_cap_bit);
                    end
                    if (op == MODE_FULL)
                    begin
                        enter_mode((caps & CAP_DRIVE) != CAP_DRIVE ? MODE_SAFE : MODE_DEGR);
                    end
                end
                EV_RECOVER:
                begin
                    refresh_caps();
                    if (is_fresh(persist_ok, persist_ms) && it.hardware_ready && can_accept())
                    begin
                        void'(apply_command(1'b1, last_str));
                    end
                    if (it.link_healthy && (caps & CAP_DRIVE) == CAP_DRIVE)
                    begin
                        enter_mode(MODE_FULL);
                    end
                    else if (it.link_connected)
                    begin
                        enter_mode(MODE_DEGR);
                    end
                end
                default: acc = 1'b0;
            endcase
            res.accepted = acc;
            res.mode_now = op;
            res.capabilities_now = caps;
            res.system_healthy = (op == MODE_FULL || op == MODE_DEGR) && it.link_healthy &&
                                 !it.estop_active;
            res.time_in_mode_ms = it.now_ms - entry_ms;
            return res;
        endfunction

        function void note_event(item_t it);
            outcomes.push_back(predict_outcome(it));
        endfunction

        function int pending();
            return outcomes.size();
        endfunction

        task report(string what, logic [31:0] want, logic [31:0] got);
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
            mismatch_count++;
        endtask

        task check_outcome(result_t got);
            result_t want;
            if (outcomes.size() == 0)
            begin
                report("unexpected result word", '0, got.mode_now);
                return;
            end
            want = outcomes.pop_front();
            if (got.accepted !== want.accepted)
                report("accepted", want.accepted, got.accepted);
            if (got.speed_drive !== want.speed_drive)
                report("speed_drive", want.speed_drive, got.speed_drive);
            if (got.speed_out !== want.speed_out)
                report("speed_out", want.speed_out, got.speed_out);
            if (got.steer_drive !== want.steer_drive)
                report("steer_drive", want.steer_drive, got.steer_drive);
            if (got.steer_out !== want.steer_out)
                report("steer_out", want.steer_out, got.steer_out);
            if (got.mode_now !== want.mode_now)
                report("mode_now", want.mode_now, got.mode_now);
            if (got.capabilities_now !== want.capabilities_now)
                report("capabilities_now", want.capabilities_now, got.capabilities_now);
            if (got.system_healthy !== want.system_healthy)
                report("system_healthy", want.system_healthy, got.system_healthy);
            if (got.time_in_mode_ms !== want.time_in_mode_ms)
                report("time_in_mode_ms", want.time_in_mode_ms, got.time_in_mode_ms);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    item_t       item;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    supervisor_board board;
    bit calm;
    int cycle_count = 0;

    degradation_mode_supervisor_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic item_t mk(logic [2:0] ev, logic [31:0] at, int val, logic [4:0] flags,
                                 logic [2:0] fc);
        item_t it;
        it.mode = ev;
        it.now_ms = at;
        it.command_value = val[15:0];
        {it.link_connected, it.link_healthy, it.safe_request, it.estop_active,
         it.hardware_ready} = flags;
        it.fail_cap_bit = fc;
        return it;
    endfunction

    function automatic item_t random_event(logic [31:0] at);
        int r;
        int val;
        logic [2:0] ev;
        logic [4:0] flags;
        r = $urandom_range(0, 99);
        if (r < 30)
            ev = EV_TICK;
        else if (r < 50)
            ev = EV_SPEED;
        else if (r < 70)
            ev = EV_STEER;
        else if (r < 78)
            ev = EV_LINK_LOSS;
        else if (r < 86)
            ev = EV_PART_FAIL;
        else if (r < 96)
            ev = EV_RECOVER;
        else
            ev = $urandom_range(0, 1) ? EV_UNDEF_A : EV_UNDEF_B;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            val = int'($urandom_range(0, 48000)) - 24000;
        end
        else if (r < 8)
        begin
            val = int'($urandom_range(0, 65535)) - 32768;
        end
        else
        begin
            case ($urandom_range(0, 7))
                0: val = -32768;
                1: val = 32767;
                2: val = 16000;
                3: val = -16000;
                4: val = 16001;
                5: val = 23040;
                6: val = -23041;
                default: val = 0;
            endcase
        end
        flags[4] = $urandom_range(0, 9) < 8;
        flags[3] = $urandom_range(0, 9) < 7;
        flags[2] = $urandom_range(0, 99) < 15;
        flags[1] = $urandom_range(0, 99) < 4;
        flags[0] = $urandom_range(0, 99) < 88;
        return mk(ev, at, val, flags, 3'($urandom_range(0, 7)));
    endfunction

    task automatic send_item(item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk) item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        board.note_event(it);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, data);
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk) item_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int n;
        int g;
        result_ready = 1'b0;
        forever
        begin
            n = $urandom_range(1, 20);
            @(negedge clk) result_ready <= 1'b1;
            repeat (n - 1) @(negedge clk);
            g = pick_gap();
            if (g > 0)
            begin
                @(negedge clk) result_ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            board.check_outcome(result);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("degradation_mode_supervisor_top verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] clock_ms;
        int p;
        int i;
        int r;
        board = new();
        calm = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed walk through the modes with reset configuration
        send_item(mk(EV_TICK, 32'd0, 0, LINK_UP_HW, 3'd0));
        send_item(mk(EV_TICK, 32'd1000, 0, LINK_UP_HW, 3'd0));
        send_item(mk(EV_SPEED, 32'd1100, 32767, LINK_UP_HW, 3'd0));
        send_item(mk(EV_SPEED, 32'd1200, -16000, LINK_UP_HW, 3'd0));
        send_item(mk(EV_STEER, 32'd1300, -32768, LINK_UP_HW, 3'd0));
        send_item(mk(EV_STEER, 32'd1400, 23040, LINK_UP_HW, 3'd0));
        send_item(mk(EV_SPEED, 32'd1500, 16000, LINK_UP_NO_HW, 3'd0));
        send_item(mk(EV_PART_FAIL, 32'd1600, 0, LINK_UP_HW, 3'd4));
        send_item(mk(EV_TICK, 32'd1700, 0, LINK_UP_HW, 3'd0));
        send_item(mk(EV_SPEED, 32'd1800, 32767, LINK_UP_HW, 3'd0));
        send_item(mk(EV_STEER, 32'd1900, -32768, LINK_UP_HW, 3'd0));
        send_item(mk(EV_LINK_LOSS, 32'd2000, 0, LINK_UP_HW, 3'd0));
        send_item(mk(EV_RECOVER, 32'd2100, 0, LINK_UP_HW, 3'd0));
        send_item(mk(EV_PART_FAIL, 32'd2200, 0, LINK_UP_HW, 3'd7));
        send_item(mk(EV_RECOVER, 32'd2300, 0, LINK_UP_HW, 3'd0));
        send_item(mk(EV_PART_FAIL, 32'd2400, 0, LINK_UP_HW, 3'd0));
        send_item(mk(EV_TICK, 32'd3500, 0, SAFE_REQ_HW, 3'd0));
        send_item(mk(EV_TICK, 32'd3600, 0, ESTOP_HW, 3'd0));
        send_item(mk(EV_SPEED, 32'd3700, 100, LINK_UP_HW, 3'd0));
        send_item(mk(EV_UNDEF_A, 32'd3800, -1, 5'b11111, 3'd5));
        send_item(mk(EV_UNDEF_B, 32'hFFFF_FFFF, 32767, 5'b00000, 3'd6));
        send_item(mk(EV_LINK_LOSS, 32'd4000, 0, LINK_UP_NO_HW, 3'd0));
        send_item(mk(EV_TICK, 32'hFFFF_FFFF, 0, CONN_ONLY, 3'd0));
        send_item(mk(EV_TICK, 32'd0, 0, LINK_DOWN_HW, 3'd0));
        send_item(mk(EV_RECOVER, 32'd5, 0, LINK_DOWN_HW, 3'd0));

        clock_ms = 32'd10000;
        for (p = 0; p < 5; p++)
        begin
            drain();
            calm = (p == 0);
            case (p)
                0:
                begin
                    write_reg(CFG_MAX_SPEED, 32'(RST_MAX_SPEED));
                    write_reg(CFG_MAX_STEER, 32'(RST_MAX_STEER));
                    write_reg(CFG_ALLOW_CACHED, 32'(RST_ALLOW_CACHED));
                    write_reg(CFG_CACHE_VALIDITY, RST_CACHE_VALIDITY);
                    write_reg(CFG_MIN_DWELL, 32'(RST_MIN_DWELL));
                end
                1:
                begin
                    write_reg(CFG_MAX_SPEED, 32'd0);
                    write_reg(CFG_MAX_STEER, 32'd0);
                    write_reg(CFG_ALLOW_CACHED, 32'd0);
                    write_reg(CFG_CACHE_VALIDITY, 32'd0);
                    write_reg(CFG_MIN_DWELL, 32'd0);
                end
                2:
                begin
                    write_reg(CFG_MAX_SPEED, 32'd16000);
                    write_reg(CFG_MAX_STEER, 32'd23040);
                    write_reg(CFG_ALLOW_CACHED, 32'd1);
                    write_reg(CFG_CACHE_VALIDITY, 32'hFFFF_FFFF);
                    write_reg(CFG_MIN_DWELL, 32'd65535);
                end
                3:
                begin
                    write_reg(CFG_MAX_SPEED, $urandom_range(0, 16000));
                    write_reg(CFG_MAX_STEER, $urandom_range(0, 23040));
                    write_reg(CFG_ALLOW_CACHED, 32'd1);
                    write_reg(CFG_CACHE_VALIDITY, $urandom_range(0, 5000));
                    write_reg(CFG_MIN_DWELL, $urandom_range(0, 3000));
                end
                default:
                begin
                    write_reg(CFG_MAX_SPEED, $urandom_range(0, 16000));
                    write_reg(CFG_MAX_STEER, $urandom_range(0, 23040));
                    write_reg(CFG_ALLOW_CACHED, $urandom_range(0, 1));
                    write_reg(CFG_CACHE_VALIDITY, $urandom());
                    write_reg(CFG_MIN_DWELL, $urandom_range(0, 65535));
                end
            endcase
            for (i = 0; i < 200; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    clock_ms = clock_ms + $urandom_range(0, 400);
                else if (r < 95)
                    clock_ms = clock_ms + $urandom_range(400, 3000);
                else if (r < 99)
                    clock_ms = clock_ms + $urandom_range(3000, 80000);
                else
                    clock_ms = $urandom();
                send_item(random_event(clock_ms));
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (board.mismatch_count == 0 && board.pending() == 0)
        begin
            $display("degradation_mode_supervisor_top verification clean");
        end
        else
        begin
            $display("degradation_mode_supervisor_top verification failed");
        end
        $finish;
    end

endmodule
